[sv/svfbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svfbm_pkg
// Types and fixed widths for the state-variable bandpass bank mixer.
// ----------------------------------------------------------------------------
package svfbm_pkg;

	localparam int SMP_W  = 24;  // Q1.23 sample and result
	localparam int COEF_W = 24;  // unsigned Q1.23 coefficient, Q4.20 gain
	localparam int INT_W  = 32;  // Q8.24 integrator
	localparam int ACC_W  = 40;  // Q16.24 mix accumulator
	localparam int V3_W   = 34;  // x - ic2
	localparam int V_W    = 36;  // v1, v2
	localparam int MA_W   = COEF_W + 1;    // multiplier operand A, signed
	localparam int MB_W   = V_W;           // multiplier operand B, signed
	localparam int PROD_W = MA_W + MB_W;   // full product
	localparam int DBL_W  = V_W + 2;       // 2*v - ic before clamp
	localparam int TERM_W = PROD_W - 20;   // gained term, Q17.24
	localparam int SUM_W  = TERM_W + 1;    // accumulator plus term

	localparam int COEF_SHIFT = 23;
	localparam int GAIN_SHIFT = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,  // a1 * ic1
		ST_MUL2,  // a2 * v3
		ST_MUL3,  // a2 * ic1
		ST_MUL4,  // a3 * v3
		ST_MUL5,  // v1 * gain
		ST_ACC,
		ST_OUT
	} svfbm_state_t;

endpackage

[sv/svf_bandpass_bank_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_bandpass_bank_mixer
// Bank of TPT state-variable bandpass filters with a gained, saturated mix.
// ----------------------------------------------------------------------------
// Each input transfer updates one band: its two Q8.24 integrators advance with
// the given a1/a2/a3 and gain times the bandpass output is added to a
// saturating 40-bit accumulator. A transfer flagged last_band emits one result
// (rounded, saturated Q1.23 mix plus a clip flag) and clears the accumulator.
// One 25x36 signed multiplier is shared over five products per band under a
// small sequencer: an in-range band with enable set runs ST_MUL1 to ST_MUL5
// and ST_ACC before the next acceptance, plus ST_OUT, which loads the result
// into the output register, when it ends the time step. A band index at or
// beyond BANDS, or any transfer with enable clear, skips these steps and
// passes ST_OUT only with last_band. The output register frees the input side:
// a new item is taken while a result still waits, and the block stalls only
// when a second result is ready before the first has been taken. With enable
// clear a last_band transfer returns its sample unchanged and no state moves.
// ----------------------------------------------------------------------------

module svf_bandpass_bank_mixer #(
	parameter int BANDS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                enable,
	// input items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [svfbm_pkg::SMP_W-1:0]  sample_in,
	input  logic        [2:0]                   band_index,
	input  logic        [svfbm_pkg::COEF_W-1:0] coef_a1,
	input  logic        [svfbm_pkg::COEF_W-1:0] coef_a2,
	input  logic        [svfbm_pkg::COEF_W-1:0] coef_a3,
	input  logic        [svfbm_pkg::COEF_W-1:0] band_gain,
	input  logic                                last_band,
	// results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [svfbm_pkg::SMP_W-1:0]  mix_out,
	output logic                                saturated
);

	localparam int IDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;

	localparam int SMP_W  = svfbm_pkg::SMP_W;
	localparam int COEF_W = svfbm_pkg::COEF_W;
	localparam int INT_W  = svfbm_pkg::INT_W;
	localparam int ACC_W  = svfbm_pkg::ACC_W;
	localparam int V3_W   = svfbm_pkg::V3_W;
	localparam int V_W    = svfbm_pkg::V_W;
	localparam int MA_W   = svfbm_pkg::MA_W;
	localparam int MB_W   = svfbm_pkg::MB_W;
	localparam int PROD_W = svfbm_pkg::PROD_W;
	localparam int DBL_W  = svfbm_pkg::DBL_W;
	localparam int TERM_W = svfbm_pkg::TERM_W;
	localparam int SUM_W  = svfbm_pkg::SUM_W;

	// saturate a 2*v - ic value to the integrator range
	function automatic logic signed [INT_W-1:0] sat_int(input logic signed [DBL_W-1:0] v);
		if (v[DBL_W-1:INT_W-1] == '0 || v[DBL_W-1:INT_W-1] == '1) begin
			sat_int = v[INT_W-1:0];
		end else begin
			sat_int = v[DBL_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end
	endfunction

	function automatic logic clip_int(input logic signed [DBL_W-1:0] v);
		clip_int = !(v[DBL_W-1:INT_W-1] == '0 || v[DBL_W-1:INT_W-1] == '1);
	endfunction

	// round half up a coefficient product sum back to Q12.24
	function automatic logic signed [V_W-1:0] round_coef(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + (PROD_W'(1) <<< (svfbm_pkg::COEF_SHIFT - 1));
		round_coef = t[svfbm_pkg::COEF_SHIFT+V_W-1:svfbm_pkg::COEF_SHIFT];
	endfunction

	// ------------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------------
	svfbm_pkg::svfbm_state_t state_q, state_d;

	logic                      enable_q;
	logic signed [INT_W-1:0]   ic1_mem_q [BANDS];
	logic signed [INT_W-1:0]   ic2_mem_q [BANDS];
	logic signed [ACC_W-1:0]   acc_q;
	logic                      clip_q;

	logic signed [SMP_W-1:0]   x_q;
	logic        [COEF_W-1:0]  a1_q, a2_q, a3_q, gain_q;
	logic                      last_q;
	logic                      byp_q;
	logic        [IDX_W-1:0]   idx_q;
	logic signed [INT_W-1:0]   cur1_q, cur2_q;
	logic signed [V3_W-1:0]    v3_q;
	logic signed [V_W-1:0]     v1_q, v2_q;
	logic signed [PROD_W-1:0]  prod_q, sum_q;

	logic                      out_valid_q;
	logic signed [SMP_W-1:0]   mix_q;
	logic                      sat_q;

	// ------------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------------
	logic             in_xfer;
	logic [IDX_W-1:0] in_idx;
	logic             in_band_ok;
	logic             out_load;

	assign cfg_ready  = 1'b1;
	assign in_xfer    = in_valid && in_ready;
	assign in_idx     = IDX_W'(band_index);
	assign in_band_ok = 32'(band_index) < BANDS;

	assign out_valid  = out_valid_q;
	assign mix_out    = mix_q;
	assign saturated  = sat_q;

	// ------------------------------------------------------------------------
	// Shared multiplier: operand select by sequencer step
	// ------------------------------------------------------------------------
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_c;

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			svfbm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			svfbm_pkg::ST_MUL1: begin
				mul_a = MA_W'(a1_q);
				mul_b = MB_W'(cur1_q);
			end
			svfbm_pkg::ST_MUL2: begin
				mul_a = MA_W'(a2_q);
				mul_b = MB_W'(v3_q);
			end
			svfbm_pkg::ST_MUL3: begin
				mul_a = MA_W'(a2_q);
				mul_b = MB_W'(cur1_q);
			end
			svfbm_pkg::ST_MUL4: begin
				mul_a = MA_W'(a3_q);
				mul_b = MB_W'(v3_q);
			end
			svfbm_pkg::ST_MUL5: begin
				mul_a = MA_W'(gain_q);
				mul_b = v1_q;
			end
			svfbm_pkg::ST_ACC: begin
			end
			svfbm_pkg::ST_OUT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svfbm_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (enable_q && in_band_ok) begin
						state_d = svfbm_pkg::ST_MUL1;
					end else if (last_band) begin
						state_d = svfbm_pkg::ST_OUT;
					end
				end
			end
			svfbm_pkg::ST_MUL1: state_d = svfbm_pkg::ST_MUL2;
			svfbm_pkg::ST_MUL2: state_d = svfbm_pkg::ST_MUL3;
			svfbm_pkg::ST_MUL3: state_d = svfbm_pkg::ST_MUL4;
			svfbm_pkg::ST_MUL4: state_d = svfbm_pkg::ST_MUL5;
			svfbm_pkg::ST_MUL5: state_d = svfbm_pkg::ST_ACC;
			svfbm_pkg::ST_ACC: begin
				state_d = last_q ? svfbm_pkg::ST_OUT : svfbm_pkg::ST_IDLE;
			end
			svfbm_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = svfbm_pkg::ST_IDLE;
				end
			end
			default: state_d = svfbm_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// Datapath arithmetic
	// ------------------------------------------------------------------------
	logic signed [V3_W-1:0]   v3_c;
	logic signed [DBL_W-1:0]  ic1_dbl, ic2_dbl;
	logic signed [PROD_W-1:0] term_rnd;
	logic signed [TERM_W-1:0] term_c;
	logic signed [SUM_W-1:0]  acc_sum;
	logic                     acc_ovf;
	logic signed [ACC_W-1:0]  acc_new;
	logic signed [ACC_W:0]    y_rnd;
	logic signed [ACC_W-1:0]  y_half;
	logic                     y_ovf;
	logic signed [SMP_W-1:0]  y_sat;

	// v3 = x - ic2, sample moved to Q8.24
	assign v3_c = (V3_W'(x_q) <<< 1) - V3_W'(cur2_q);

	// next integrator values before clamping
	assign ic1_dbl = (DBL_W'(v1_q) <<< 1) - DBL_W'(cur1_q);
	assign ic2_dbl = (DBL_W'(v2_q) <<< 1) - DBL_W'(cur2_q);

	// gained bandpass term, round half up to Q17.24
	assign term_rnd = prod_q + (PROD_W'(1) <<< (svfbm_pkg::GAIN_SHIFT - 1));
	assign term_c   = term_rnd[PROD_W-1:svfbm_pkg::GAIN_SHIFT];
	assign acc_sum  = SUM_W'(acc_q) + SUM_W'(term_c);
	assign acc_ovf  = !(acc_sum[SUM_W-1:ACC_W-1] == '0 || acc_sum[SUM_W-1:ACC_W-1] == '1);
	assign acc_new  = acc_ovf ?
		(acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		acc_sum[ACC_W-1:0];

	// mix: Q16.24 to Q1.23 with round half up, then clamp
	assign y_rnd  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(1);
	assign y_half = y_rnd[ACC_W:1];
	assign y_ovf  = !(y_half[ACC_W-1:SMP_W-1] == '0 || y_half[ACC_W-1:SMP_W-1] == '1);
	assign y_sat  = y_ovf ?
		(y_half[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}}) :
		y_half[SMP_W-1:0];

	// ------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svfbm_pkg::ST_IDLE;
			enable_q    <= 1'b1;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < BANDS; i++) begin
				ic1_mem_q[i] <= '0;
				ic2_mem_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				enable_q <= enable;
			end

			// write back the first integrator once v1 is known
			if (state_q == svfbm_pkg::ST_MUL4) begin
				ic1_mem_q[idx_q] <= sat_int(ic1_dbl);
				if (clip_int(ic1_dbl)) begin
					clip_q <= 1'b1;
				end
			end

			// second integrator and the mix term land together
			if (state_q == svfbm_pkg::ST_ACC) begin
				ic2_mem_q[idx_q] <= sat_int(ic2_dbl);
				acc_q            <= acc_new;
				if (clip_int(ic2_dbl) || acc_ovf) begin
					clip_q <= 1'b1;
				end
			end

			// emit the result; a filtered time step clears its mix state
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!byp_q) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q    <= sample_in;
			a1_q   <= coef_a1;
			a2_q   <= coef_a2;
			a3_q   <= coef_a3;
			gain_q <= band_gain;
			last_q <= last_band;
			byp_q  <= !enable_q;
			idx_q  <= in_idx;
			cur1_q <= ic1_mem_q[in_idx];
			cur2_q <= ic2_mem_q[in_idx];
		end

		// hold the previous product for the pairwise sums
		if (state_q != svfbm_pkg::ST_IDLE) begin
			prod_q <= prod_c;
		end

		case (state_q)
			svfbm_pkg::ST_MUL1: v3_q  <= v3_c;
			svfbm_pkg::ST_MUL2: sum_q <= prod_q;
			svfbm_pkg::ST_MUL3: v1_q  <= round_coef(sum_q + prod_q);
			svfbm_pkg::ST_MUL4: sum_q <= prod_q;
			svfbm_pkg::ST_MUL5: v2_q  <= V_W'(cur2_q) + round_coef(sum_q + prod_q);
			default: begin
			end
		endcase

		if (out_load) begin
			if (byp_q) begin
				mix_q <= x_q;
				sat_q <= 1'b0;
			end else begin
				mix_q <= y_sat;
				sat_q <= clip_q || y_ovf;
			end
		end
	end

endmodule
